// ===== rtl/core/nbge_pkg.sv =====
// shared types, codes and helpers for the n-body gravity euler step unit
package nbge_pkg;

    // request modes
    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_ADVANCE = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;
    localparam logic [1:0] MODE_REMOVE  = 2'd3;

    // configuration register indexes
    localparam logic CFG_TIME_STEP  = 1'b0;
    localparam logic CFG_GRAV_CONST = 1'b1;

    localparam logic [15:0] TIME_STEP_RST  = 16'd256;
    localparam logic [31:0] GRAV_CONST_RST = 32'd1231135700;

    // velocity accumulator width, room for 256 bodies of 34-bit speed changes
    localparam int ACC_W = 48;

    localparam logic [48:0] K_LIMIT   = {49{1'b1}};
    localparam logic [30:0] SEP_LIMIT = {31{1'b1}};

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic        [47:0] mass;
        logic        [15:0] radius;
    } t_body;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sd2147483647);
        lo = -ACC_W'(64'sd2147483648);
        if (v > hi) begin
            sat32 = 32'sh7fffffff;
        end else if (v < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage

// ===== rtl/core/nbody_gravity_euler_step_unit.sv =====
// top level of the n-body gravity euler step unit: body table, force sweep, collision sweep
//
// channel   direction  handshake                      payload
// request   in         i_in_valid / o_in_ready        i_mode, i_body_index, i_pos_*, i_vel_*,
//                                                     i_body_mass, i_body_radius
// result    out        o_out_valid / i_out_ready      o_index_out, o_alive, o_new_*,
//                                                     o_collided, o_partner_index
// config    in         i_cfg_we (no wait)             i_cfg_index, i_cfg_data
//
// a write goes straight to the result step; read, remove and an advance of a dead body
//   first read the table entry
// advance of a live body: a force sweep, then a collision sweep up to the first collision;
//   the force sweep does pair work only for other live bodies at nonzero separation, the
//   collision sweep its distance test only for a close one; the per-body cost comes from
//   the shared radix-2 divider (three divisions per pair) and the 32-step square root
// one request is worked on at a time; the result register lets the next request in
//   while the previous result still waits on i_out_ready, a further result then waits
//   in the last step until the register frees up
// reset is synchronous, clears the live and written marks and restores the config
//   defaults; the body table itself has no reset, entries never written read as zero
module nbody_gravity_euler_step_unit #(
    parameter int BODY_COUNT = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_mode,
    input  logic [3:0]         i_body_index,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic [47:0]        i_body_mass,
    input  logic [15:0]        i_body_radius,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [3:0]         o_index_out,
    output logic               o_alive,
    output logic signed [31:0] o_new_pos_x,
    output logic signed [31:0] o_new_pos_y,
    output logic signed [31:0] o_new_vel_x,
    output logic signed [31:0] o_new_vel_y,
    output logic               o_collided,
    output logic [3:0]         o_partner_index,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int AW = (BODY_COUNT > 1) ? $clog2(BODY_COUNT) : 1;
    localparam logic [AW-1:0]   J_LAST  = AW'(BODY_COUNT - 1);
    localparam logic [AW+3:0]   IDX_LIM = (AW + 4)'(BODY_COUNT);
    localparam int ACC_W = nbge_pkg::ACC_W;

    // sequencer codes
    localparam logic [5:0] S_IDLE  = 6'd0;
    localparam logic [5:0] S_SELF  = 6'd1;
    localparam logic [5:0] S_PINIT = 6'd2;
    localparam logic [5:0] S_JISS  = 6'd3;
    localparam logic [5:0] S_JDAT  = 6'd4;
    localparam logic [5:0] S_SQX   = 6'd5;
    localparam logic [5:0] S_SQY   = 6'd6;
    localparam logic [5:0] S_SQS   = 6'd7;
    localparam logic [5:0] S_SQRT  = 6'd8;
    localparam logic [5:0] S_QM0   = 6'd9;
    localparam logic [5:0] S_QM1   = 6'd10;
    localparam logic [5:0] S_QM2   = 6'd11;
    localparam logic [5:0] S_QM3   = 6'd12;
    localparam logic [5:0] S_QM4   = 6'd13;
    localparam logic [5:0] S_DIVK  = 6'd14;
    localparam logic [5:0] S_UXS   = 6'd15;
    localparam logic [5:0] S_DIVUX = 6'd16;
    localparam logic [5:0] S_UYS   = 6'd17;
    localparam logic [5:0] S_DIVUY = 6'd18;
    localparam logic [5:0] S_MX0   = 6'd19;
    localparam logic [5:0] S_MX1   = 6'd20;
    localparam logic [5:0] S_MX2   = 6'd21;
    localparam logic [5:0] S_MY1   = 6'd22;
    localparam logic [5:0] S_MY2   = 6'd23;
    localparam logic [5:0] S_JNXT  = 6'd24;
    localparam logic [5:0] S_VEL   = 6'd25;
    localparam logic [5:0] S_PMX   = 6'd26;
    localparam logic [5:0] S_PMY   = 6'd27;
    localparam logic [5:0] S_PWB   = 6'd28;
    localparam logic [5:0] S_WB    = 6'd29;
    localparam logic [5:0] S_CISS  = 6'd30;
    localparam logic [5:0] S_CDAT  = 6'd31;
    localparam logic [5:0] S_CX    = 6'd32;
    localparam logic [5:0] S_CY    = 6'd33;
    localparam logic [5:0] S_CR    = 6'd34;
    localparam logic [5:0] S_CCMP  = 6'd35;
    localparam logic [5:0] S_CNXT  = 6'd36;
    localparam logic [5:0] S_DONE  = 6'd37;

    // control state
    logic [5:0]            r_state, n_state;
    logic [BODY_COUNT-1:0] r_live;
    logic [BODY_COUNT-1:0] r_written;
    logic                  r_o_valid;
    logic [15:0]           r_dt;
    logic [31:0]           r_g;

    // body table, one entry per body, synchronous read
    nbge_pkg::t_body r_mem [BODY_COUNT];
    nbge_pkg::t_body r_rd;
    logic [AW-1:0]   rd_addr;
    logic            w_en;
    logic [AW-1:0]   w_addr;
    nbge_pkg::t_body w_data;

    // request context
    logic [1:0]      r_mode;
    logic [3:0]      r_idx_raw;
    logic [AW-1:0]   r_idx;
    logic            r_idx_ok;
    nbge_pkg::t_body r_self;
    logic [AW-1:0]   r_j;

    // force sweep datapath
    logic [47:0]             r_p;
    logic signed [ACC_W-1:0] r_ax, r_ay;
    logic [30:0]             r_adx, r_ady;
    logic                    r_sx, r_sy;
    logic [47:0]             r_mj;
    logic [62:0]             r_d2;
    logic [63:0]             r_sq_v, r_sq_r, r_sq_bit;
    logic [5:0]              r_cnt;
    logic [49:0]             r_qacc;
    logic [63:0]             r_dv_num;
    logic [62:0]             r_dv_rem;
    logic [62:0]             r_dv_den;
    logic [48:0]             r_k;
    logic [14:0]             r_ux, r_uy;
    logic [38:0]             r_macc;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] r_mul;

    // collision sweep datapath
    logic [16:0] r_cux, r_cuy, r_rs;
    logic [34:0] r_csum;
    logic        r_coll;
    logic [3:0]  r_partner;

    // result register
    logic [3:0]         r_o_index;
    logic               r_o_alive;
    logic signed [31:0] r_o_px, r_o_py, r_o_vx, r_o_vy;
    logic               r_o_coll;
    logic [3:0]         r_o_partner;

    // request decode
    logic          in_acc;
    logic [AW+3:0] idx_ext;
    logic [AW-1:0] idx_addr;
    logic          idx_ok;
    logic [AW+3:0] j_ext;
    nbge_pkg::t_body in_body;

    assign in_acc   = i_in_valid && o_in_ready;
    assign idx_ext  = {{AW{1'b0}}, i_body_index};
    assign idx_addr = idx_ext[AW-1:0];
    assign idx_ok   = idx_ext < IDX_LIM;
    assign j_ext    = {4'b0000, r_j};
    assign in_body  = '{px: i_pos_x, py: i_pos_y, vx: i_vel_x, vy: i_vel_y,
                        mass: i_body_mass, radius: i_body_radius};

    // separation of body j from the advanced body, saturated magnitude and sign
    logic signed [32:0] dfx, dfy;
    logic [32:0]        abx, aby;
    logic [30:0]        magx, magy;
    assign dfx  = {r_rd.px[31], r_rd.px} - {r_self.px[31], r_self.px};
    assign dfy  = {r_rd.py[31], r_rd.py} - {r_self.py[31], r_self.py};
    assign abx  = dfx[32] ? 33'(-dfx) : 33'(dfx);
    assign aby  = dfy[32] ? 33'(-dfy) : 33'(dfy);
    assign magx = (abx > {2'b00, nbge_pkg::SEP_LIMIT}) ? nbge_pkg::SEP_LIMIT : abx[30:0];
    assign magy = (aby > {2'b00, nbge_pkg::SEP_LIMIT}) ? nbge_pkg::SEP_LIMIT : aby[30:0];

    // summed radii for the collision test
    logic [16:0] rsum;
    assign rsum = {1'b0, r_self.radius} + {1'b0, r_rd.radius};

    // divider step, one quotient bit per cycle
    logic [63:0] dv_sh;
    logic        dv_ge;
    logic [63:0] dv_sub;
    assign dv_sh  = {r_dv_rem, r_dv_num[63]};
    assign dv_ge  = dv_sh >= {1'b0, r_dv_den};
    assign dv_sub = dv_sh - {1'b0, r_dv_den};

    // square root step, two radicand bits per cycle
    logic [63:0] sq_t;
    logic        sq_ge;
    assign sq_t  = r_sq_r + r_sq_bit;
    assign sq_ge = r_sq_v >= sq_t;

    // speed change from the two partial products of k*u
    logic [63:0] ku;
    logic [33:0] dv;
    assign ku = {r_mul[39:0], 24'b0} + {25'b0, r_macc};
    assign dv = ku[63:30];

    // position step: floor(v*dt/256) from |v|*dt
    logic        step_neg;
    logic [47:0] step_up;
    logic signed [ACC_W-1:0] dlt;
    logic signed [31:0]      step_pos;
    logic signed [31:0]      pos_new;
    assign step_neg = (r_state == S_PMY) ? r_self.vx[31] : r_self.vy[31];
    assign step_pos = (r_state == S_PMY) ? r_self.px : r_self.py;
    assign step_up  = r_mul[47:0] + 48'd255;
    assign dlt      = step_neg ? -ACC_W'({8'b0, step_up[47:8]}) : ACC_W'({8'b0, r_mul[47:8]});
    assign pos_new  = nbge_pkg::sat32(ACC_W'(step_pos) + dlt);

    logic [31:0] vmag_x, vmag_y;
    assign vmag_x = r_self.vx[31] ? 32'(-r_self.vx) : 32'(r_self.vx);
    assign vmag_y = r_self.vy[31] ? 32'(-r_self.vy) : 32'(r_self.vy);

    // operand select of the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SELF: begin
                mul_a = r_g;
                mul_b = {16'b0, r_dt};
            end
            S_SQX: begin
                mul_a = {1'b0, r_adx};
                mul_b = {1'b0, r_adx};
            end
            S_SQY: begin
                mul_a = {1'b0, r_ady};
                mul_b = {1'b0, r_ady};
            end
            S_QM0: begin
                mul_a = {8'b0, r_p[23:0]};
                mul_b = {8'b0, r_mj[23:0]};
            end
            S_QM1: begin
                mul_a = {8'b0, r_p[47:24]};
                mul_b = {8'b0, r_mj[23:0]};
            end
            S_QM2: begin
                mul_a = {8'b0, r_p[23:0]};
                mul_b = {8'b0, r_mj[47:24]};
            end
            S_QM3: begin
                mul_a = {8'b0, r_p[47:24]};
                mul_b = {8'b0, r_mj[47:24]};
            end
            S_MX0: begin
                mul_a = {8'b0, r_k[23:0]};
                mul_b = {17'b0, r_ux};
            end
            S_MX1: begin
                mul_a = {7'b0, r_k[48:24]};
                mul_b = {17'b0, r_ux};
            end
            S_MX2: begin
                mul_a = {8'b0, r_k[23:0]};
                mul_b = {17'b0, r_uy};
            end
            S_MY1: begin
                mul_a = {7'b0, r_k[48:24]};
                mul_b = {17'b0, r_uy};
            end
            S_PMX: begin
                mul_a = vmag_x;
                mul_b = {16'b0, r_dt};
            end
            S_PMY: begin
                mul_a = vmag_y;
                mul_b = {16'b0, r_dt};
            end
            S_CX: begin
                mul_a = {15'b0, r_cux};
                mul_b = {15'b0, r_cux};
            end
            S_CY: begin
                mul_a = {15'b0, r_cuy};
                mul_b = {15'b0, r_cuy};
            end
            S_CR: begin
                mul_a = {15'b0, r_rs};
                mul_b = {15'b0, r_rs};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // table port select: a write request writes at accept, an advance writes back after its step
    always_comb begin
        case (r_state)
            S_IDLE:  rd_addr = idx_addr;
            S_JISS:  rd_addr = r_j;
            S_CISS:  rd_addr = r_j;
            default: rd_addr = r_idx;
        endcase
        w_en   = (r_state == S_WB) ||
                 (in_acc && idx_ok && (i_mode == nbge_pkg::MODE_WRITE));
        w_addr = (r_state == S_WB) ? r_idx : idx_addr;
        w_data = (r_state == S_WB) ? r_self : in_body;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!idx_ok || i_mode == nbge_pkg::MODE_WRITE) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SELF;
                    end
                end
            end
            S_SELF: begin
                if (r_mode == nbge_pkg::MODE_ADVANCE && r_live[r_idx]) begin
                    n_state = S_PINIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PINIT: n_state = S_JISS;
            S_JISS: begin
                if (r_j == r_idx || !r_live[r_j]) begin
                    n_state = S_JNXT;
                end else begin
                    n_state = S_JDAT;
                end
            end
            S_JDAT: begin
                // a pair at zero separation adds nothing
                if (r_rd.px == r_self.px && r_rd.py == r_self.py) begin
                    n_state = S_JNXT;
                end else begin
                    n_state = S_SQX;
                end
            end
            S_SQX:   n_state = S_SQY;
            S_SQY:   n_state = S_SQS;
            S_SQS:   n_state = S_SQRT;
            S_SQRT:  n_state = (r_cnt == 6'd0) ? S_QM0 : S_SQRT;
            S_QM0:   n_state = S_QM1;
            S_QM1:   n_state = S_QM2;
            S_QM2:   n_state = S_QM3;
            S_QM3:   n_state = S_QM4;
            S_QM4:   n_state = S_DIVK;
            S_DIVK:  n_state = (r_cnt == 6'd0) ? S_UXS : S_DIVK;
            S_UXS:   n_state = S_DIVUX;
            S_DIVUX: n_state = (r_cnt == 6'd0) ? S_UYS : S_DIVUX;
            S_UYS:   n_state = S_DIVUY;
            S_DIVUY: n_state = (r_cnt == 6'd0) ? S_MX0 : S_DIVUY;
            S_MX0:   n_state = S_MX1;
            S_MX1:   n_state = S_MX2;
            S_MX2:   n_state = S_MY1;
            S_MY1:   n_state = S_MY2;
            S_MY2:   n_state = S_JNXT;
            S_JNXT:  n_state = (r_j == J_LAST) ? S_VEL : S_JISS;
            S_VEL:   n_state = S_PMX;
            S_PMX:   n_state = S_PMY;
            S_PMY:   n_state = S_PWB;
            S_PWB:   n_state = S_WB;
            S_WB:    n_state = S_CISS;
            S_CISS: begin
                if (r_j == r_idx || !r_live[r_j]) begin
                    n_state = S_CNXT;
                end else begin
                    n_state = S_CDAT;
                end
            end
            S_CDAT: begin
                if (abx > {16'b0, rsum} || aby > {16'b0, rsum}) begin
                    n_state = S_CNXT;
                end else begin
                    n_state = S_CX;
                end
            end
            S_CX:    n_state = S_CY;
            S_CY:    n_state = S_CR;
            S_CR:    n_state = S_CCMP;
            S_CCMP:  n_state = ({1'b0, r_csum} <= r_mul[35:0]) ? S_DONE : S_CNXT;
            S_CNXT:  n_state = (r_j == J_LAST) ? S_DONE : S_CISS;
            S_DONE: begin
                if (!r_o_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_live    <= '0;
            r_written <= '0;
            r_o_valid <= 1'b0;
            r_dt      <= nbge_pkg::TIME_STEP_RST;
            r_g       <= nbge_pkg::GRAV_CONST_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == nbge_pkg::CFG_TIME_STEP) begin
                    r_dt <= i_cfg_data[15:0];
                end else begin
                    r_g <= i_cfg_data;
                end
            end
            if (in_acc && idx_ok && i_mode == nbge_pkg::MODE_WRITE) begin
                r_live[idx_addr]    <= 1'b1;
                r_written[idx_addr] <= 1'b1;
            end
            if (r_state == S_SELF && r_mode == nbge_pkg::MODE_REMOVE) begin
                r_live[r_idx] <= 1'b0;
            end
            // a collision kills both bodies
            if (r_state == S_CCMP && {1'b0, r_csum} <= r_mul[35:0]) begin
                r_live[r_idx] <= 1'b0;
                r_live[r_j]   <= 1'b0;
            end
            if (r_state == S_DONE && (!r_o_valid || i_out_ready)) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_mul <= 64'(mul_a) * 64'(mul_b);
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_mode    <= i_mode;
                    r_idx_raw <= i_body_index;
                    r_idx     <= idx_addr;
                    r_idx_ok  <= idx_ok;
                    r_coll    <= 1'b0;
                    r_partner <= '0;
                    r_self    <= (idx_ok && i_mode == nbge_pkg::MODE_WRITE) ? in_body : '0;
                end
            end
            S_SELF: begin
                r_self <= r_written[r_idx] ? r_rd : '0;
            end
            S_PINIT: begin
                r_p  <= r_mul[47:0];
                r_ax <= ACC_W'(r_self.vx);
                r_ay <= ACC_W'(r_self.vy);
                r_j  <= '0;
            end
            S_JDAT: begin
                r_adx <= magx;
                r_ady <= magy;
                r_sx  <= dfx[32];
                r_sy  <= dfy[32];
                r_mj  <= r_rd.mass;
            end
            S_SQY: begin
                r_d2 <= r_mul[62:0];
            end
            S_SQS: begin
                r_d2     <= r_d2 + r_mul[62:0];
                r_sq_v   <= {1'b0, r_d2 + r_mul[62:0]};
                r_sq_r   <= '0;
                r_sq_bit <= 64'h4000_0000_0000_0000;
                r_cnt    <= 6'd31;
            end
            S_SQRT: begin
                if (sq_ge) begin
                    r_sq_v <= r_sq_v - sq_t;
                    r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
                end else begin
                    r_sq_r <= r_sq_r >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
                r_cnt    <= r_cnt - 6'd1;
            end
            S_QM1: begin
                r_qacc <= {26'b0, r_mul[47:24]};
            end
            S_QM2: begin
                r_qacc <= r_qacc + {2'b0, r_mul[47:0]};
            end
            S_QM3: begin
                r_qacc <= r_qacc + {2'b0, r_mul[47:0]};
            end
            S_QM4: begin
                r_dv_num <= {r_mul[47:0] + {22'b0, r_qacc[49:24]}, 16'b0};
                r_dv_rem <= '0;
                r_dv_den <= r_d2;
                r_cnt    <= 6'd63;
            end
            S_DIVK, S_DIVUX, S_DIVUY: begin
                r_dv_rem <= dv_ge ? dv_sub[62:0] : dv_sh[62:0];
                r_dv_num <= {r_dv_num[62:0], dv_ge};
                r_cnt    <= r_cnt - 6'd1;
            end
            S_UXS: begin
                r_k      <= (r_dv_num > {15'b0, nbge_pkg::K_LIMIT}) ?
                            nbge_pkg::K_LIMIT : r_dv_num[48:0];
                r_dv_num <= {r_adx, 33'b0};
                r_dv_rem <= '0;
                r_dv_den <= {31'b0, r_sq_r[31:0]};
                r_cnt    <= 6'd44;
            end
            S_UYS: begin
                r_ux     <= r_dv_num[14:0];
                r_dv_num <= {r_ady, 33'b0};
                r_dv_rem <= '0;
                r_cnt    <= 6'd44;
            end
            S_MX0: begin
                r_uy <= r_dv_num[14:0];
            end
            S_MX1, S_MY1: begin
                r_macc <= r_mul[38:0];
            end
            S_MX2: begin
                r_ax <= r_sx ? r_ax - ACC_W'(dv) : r_ax + ACC_W'(dv);
            end
            S_MY2: begin
                r_ay <= r_sy ? r_ay - ACC_W'(dv) : r_ay + ACC_W'(dv);
            end
            S_JNXT, S_CNXT: begin
                r_j <= r_j + AW'(1);
            end
            S_VEL: begin
                r_self.vx <= nbge_pkg::sat32(r_ax);
                r_self.vy <= nbge_pkg::sat32(r_ay);
            end
            S_PMY: begin
                r_self.px <= pos_new;
            end
            S_PWB: begin
                r_self.py <= pos_new;
            end
            S_WB: begin
                r_j <= '0;
            end
            S_CDAT: begin
                r_cux <= abx[16:0];
                r_cuy <= aby[16:0];
                r_rs  <= rsum;
            end
            S_CY: begin
                r_csum <= {1'b0, r_mul[33:0]};
            end
            S_CR: begin
                r_csum <= r_csum + {1'b0, r_mul[33:0]};
            end
            S_CCMP: begin
                if ({1'b0, r_csum} <= r_mul[35:0]) begin
                    r_coll    <= 1'b1;
                    r_partner <= j_ext[3:0];
                end
            end
            S_DONE: begin
                if (!r_o_valid || i_out_ready) begin
                    r_o_index   <= r_idx_raw;
                    r_o_alive   <= r_idx_ok && r_live[r_idx];
                    r_o_px      <= r_self.px;
                    r_o_py      <= r_self.py;
                    r_o_vx      <= r_self.vx;
                    r_o_vy      <= r_self.vy;
                    r_o_coll    <= r_coll;
                    r_o_partner <= r_partner;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_o_valid;
    assign o_index_out     = r_o_index;
    assign o_alive         = r_o_alive;
    assign o_new_pos_x     = r_o_px;
    assign o_new_pos_y     = r_o_py;
    assign o_new_vel_x     = r_o_vx;
    assign o_new_vel_y     = r_o_vy;
    assign o_collided      = r_o_coll;
    assign o_partner_index = r_o_partner;

endmodule

// ===== rtl/core/nbge_checker.sv =====
// port-level checks of the n-body gravity euler step unit, bound to the top level
module nbge_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [3:0] o_index_out,
    input logic       o_alive,
    input logic       o_collided,
    input logic [3:0] o_partner_index
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_index_out))
        else $error("result changed while stalled");

    // one request in flight
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while busy");

    // a collision leaves the body dead
    a_coll_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_collided |-> !o_alive)
        else $error("collided body reported alive");

    // no partner without a collision
    a_partner_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_collided |-> o_partner_index == 4'd0)
        else $error("partner index without collision");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind nbody_gravity_euler_step_unit nbge_checker u_nbge_checker (.*);
